>>> rtl/core/tcw_pkg.sv
package tcw_pkg;

    localparam int DEF_SCREEN_COLS = 80;
    localparam int DEF_SCREEN_ROWS = 25;

    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int COL_IN_W   = 7;
    localparam int ROW_IN_W   = 5;
    localparam int LIN_W      = 11;
    localparam int ATTR_SHIFT = 8;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd15;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        MODE_PUTC   = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_SETCUR = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_CLEAR,
        OP_SETCUR,
        OP_READ
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COPY,
        ST_BLANK,
        ST_FILL,
        ST_READ,
        ST_DONE
    } t_state;

    // Column and row are already clamped to the screen, so the input widths suffice.
    typedef struct packed {
        t_op                 op;
        logic [CHAR_W-1:0]   ch;
        logic [COL_IN_W-1:0] col;
        logic [ROW_IN_W-1:0] row;
        logic [CELL_W-1:0]   fill;
    } t_cmd;

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

    function automatic logic [CELL_W-1:0] build_cell(logic [CHAR_W-1:0] ch,
                                                     logic [ATTR_W-1:0] attr);
        build_cell = (CELL_W'(attr) << ATTR_SHIFT) | CELL_W'(ch);
    endfunction

    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, SPACE_CODE};

endpackage

>>> rtl/core/tcw_ifs.sv
interface tcw_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::COL_IN_W-1:0]  cursor_col;
    logic [tcw_pkg::ROW_IN_W-1:0]  cursor_row;
    logic [tcw_pkg::CELL_W-1:0]    fill_entry;

    modport source (output valid, mode, char_code, cursor_col, cursor_row, fill_entry,
                    input ready);
    modport sink   (input valid, mode, char_code, cursor_col, cursor_row, fill_entry,
                    output ready);
endinterface

interface tcw_res_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::COL_IN_W-1:0]  col_now;
    logic [tcw_pkg::ROW_IN_W-1:0]  row_now;
    logic [tcw_pkg::LIN_W-1:0]     linear_pos;
    logic                          scrolled;
    logic [tcw_pkg::CELL_W-1:0]    cell_value;

    modport source (output valid, col_now, row_now, linear_pos, scrolled, cell_value,
                    input ready);
    modport sink   (input valid, col_now, row_now, linear_pos, scrolled, cell_value,
                    output ready);
endinterface

>>> rtl/core/tcw_front.sv
module tcw_front #(
    parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tcw_cmd_if.sink            i_cmd,
    input  tcw_pkg::t_back_stat i_stat,
    input  logic               i_q_full,
    output logic               o_q_push,
    output tcw_pkg::t_cmd      o_q_data
);

    logic          r_valid;
    tcw_pkg::t_cmd r_cmd;
    tcw_pkg::t_cmd n_cmd;
    logic          accept;

    assign o_q_push    = r_valid && !i_q_full;
    // No item enters while the screen store is still being cleared after reset.
    assign i_cmd.ready = (!r_valid || o_q_push) && !i_stat.init_busy;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign o_q_data    = r_cmd;

    always_comb begin
        n_cmd.ch   = i_cmd.char_code;
        n_cmd.fill = i_cmd.fill_entry;
        if (int'(i_cmd.cursor_col) > SCREEN_COLS - 1) begin
            n_cmd.col = tcw_pkg::COL_IN_W'(SCREEN_COLS - 1);
        end else begin
            n_cmd.col = i_cmd.cursor_col;
        end
        if (int'(i_cmd.cursor_row) > SCREEN_ROWS - 1) begin
            n_cmd.row = tcw_pkg::ROW_IN_W'(SCREEN_ROWS - 1);
        end else begin
            n_cmd.row = i_cmd.cursor_row;
        end
        unique case (tcw_pkg::t_mode'(i_cmd.mode))
            tcw_pkg::MODE_PUTC: begin
                if (i_cmd.char_code == tcw_pkg::NEWLINE_CODE) begin
                    n_cmd.op = tcw_pkg::OP_NEWLINE;
                end else begin
                    n_cmd.op = tcw_pkg::OP_CHAR;
                end
            end
            tcw_pkg::MODE_CLEAR:  n_cmd.op = tcw_pkg::OP_CLEAR;
            tcw_pkg::MODE_SETCUR: n_cmd.op = tcw_pkg::OP_SETCUR;
            tcw_pkg::MODE_READ:   n_cmd.op = tcw_pkg::OP_READ;
            default:              n_cmd.op = tcw_pkg::OP_READ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

>>> rtl/core/tcw_queue.sv
module tcw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output tcw_pkg::t_cmd o_head
);

    localparam int PTR_W = $clog2(tcw_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

    tcw_pkg::t_cmd    r_slot [tcw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(tcw_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/core/tcw_back.sv
module tcw_back #(
    parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_wdata,
    input  logic                       i_q_empty,
    input  tcw_pkg::t_cmd              i_q_head,
    output logic                       o_q_pop,
    output tcw_pkg::t_back_stat        o_stat,
    tcw_res_if.source                  o_res
);

    localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
    localparam int COPY_N = SCREEN_COLS * (SCREEN_ROWS - 1);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(SCREEN_COLS);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);

    tcw_pkg::t_state r_st, n_st;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [ADDR_W-1:0] r_widx, n_widx;
    logic              r_issue, n_issue;
    logic              r_pend, n_pend;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_scr, n_scr;
    logic [tcw_pkg::CELL_W-1:0] r_cell, n_cell;
    logic [tcw_pkg::CELL_W-1:0] r_fill, n_fill;
    logic [tcw_pkg::ATTR_W-1:0] r_attr;

    logic [tcw_pkg::CELL_W-1:0] r_mem [CELLS];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;

    logic                         r_out_valid;
    logic [tcw_pkg::COL_IN_W-1:0] r_out_col;
    logic [tcw_pkg::ROW_IN_W-1:0] r_out_row;
    logic [tcw_pkg::LIN_W-1:0]    r_out_lin;
    logic                         r_out_scr;
    logic [tcw_pkg::CELL_W-1:0]   r_out_cell;

    logic              res_free;
    logic              load_res;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic              wrap_row;
    logic              do_scroll;

    assign res_free = !r_out_valid || o_res.ready;
    assign col_inc  = {1'b0, r_col} + 1'b1;
    assign row_inc  = {1'b0, r_row} + 1'b1;

    assign o_stat.init_busy = (r_st == tcw_pkg::ST_INIT);

    always_comb begin
        n_st      = r_st;
        n_idx     = r_idx;
        n_widx    = r_widx;
        n_issue   = r_issue;
        n_pend    = r_pend;
        n_col     = r_col;
        n_row     = r_row;
        n_scr     = r_scr;
        n_cell    = r_cell;
        n_fill    = r_fill;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = tcw_pkg::RESET_CELL;
        mem_raddr = ADDR_W'(32'(i_q_head.row) * SCREEN_COLS + 32'(i_q_head.col));
        o_q_pop   = 1'b0;
        load_res  = 1'b0;
        wrap_row  = 1'b0;
        do_scroll = 1'b0;

        unique case (r_st)
            tcw_pkg::ST_INIT: begin
                mem_we = 1'b1;
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_idx = '0;
                    n_st  = tcw_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (!i_q_empty && res_free) begin
                    o_q_pop = 1'b1;
                    n_scr   = 1'b0;
                    n_cell  = '0;
                    unique case (i_q_head.op)
                        tcw_pkg::OP_CHAR: begin
                            mem_we    = 1'b1;
                            mem_waddr = ADDR_W'(32'(r_row) * SCREEN_COLS + 32'(r_col));
                            mem_wdata = tcw_pkg::build_cell(i_q_head.ch, r_attr);
                            if (col_inc == (COL_W + 1)'(SCREEN_COLS)) begin
                                n_col    = '0;
                                wrap_row = 1'b1;
                            end else begin
                                n_col = col_inc[COL_W-1:0];
                            end
                        end
                        tcw_pkg::OP_NEWLINE: begin
                            n_col    = '0;
                            wrap_row = 1'b1;
                        end
                        tcw_pkg::OP_CLEAR: begin
                            n_col  = '0;
                            n_row  = '0;
                            n_fill = i_q_head.fill;
                            n_idx  = '0;
                            n_st   = tcw_pkg::ST_FILL;
                        end
                        tcw_pkg::OP_SETCUR: begin
                            n_col = COL_W'(i_q_head.col);
                            n_row = ROW_W'(i_q_head.row);
                        end
                        tcw_pkg::OP_READ: begin
                            n_st = tcw_pkg::ST_READ;
                        end
                        default: begin
                            n_st = tcw_pkg::ST_READ;
                        end
                    endcase
                    if (wrap_row) begin
                        if (row_inc == (ROW_W + 1)'(SCREEN_ROWS)) begin
                            do_scroll = 1'b1;
                        end else begin
                            n_row = row_inc[ROW_W-1:0];
                        end
                    end
                    if (do_scroll) begin
                        n_scr   = 1'b1;
                        n_idx   = '0;
                        n_issue = 1'b1;
                        n_pend  = 1'b0;
                        n_st    = tcw_pkg::ST_COPY;
                    end else if (i_q_head.op != tcw_pkg::OP_CLEAR &&
                                 i_q_head.op != tcw_pkg::OP_READ) begin
                        load_res = 1'b1;
                    end
                end
            end
            tcw_pkg::ST_COPY: begin
                // Read one row ahead and write the registered data in the following cycle.
                mem_raddr = ADDR_W'(32'(r_idx) + SCREEN_COLS);
                mem_waddr = r_widx;
                mem_wdata = r_rdata;
                mem_we    = r_pend;
                n_pend    = r_issue;
                if (r_issue) begin
                    n_widx = r_idx;
                    if (r_idx == ADDR_W'(COPY_N - 1)) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_idx = ADDR_W'(COPY_N);
                    n_st  = tcw_pkg::ST_BLANK;
                end
            end
            tcw_pkg::ST_BLANK: begin
                mem_we    = 1'b1;
                mem_wdata = tcw_pkg::build_cell(tcw_pkg::SPACE_CODE, r_attr);
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_st = tcw_pkg::ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tcw_pkg::ST_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = r_fill;
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_st = tcw_pkg::ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tcw_pkg::ST_READ: begin
                n_cell = r_rdata;
                n_st   = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE: begin
                if (res_free) begin
                    load_res = 1'b1;
                    n_st     = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_st = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= tcw_pkg::ST_INIT;
            r_idx       <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_attr      <= tcw_pkg::RESET_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_idx   <= n_idx;
            r_issue <= n_issue;
            r_pend  <= n_pend;
            r_col   <= n_col;
            r_row   <= n_row;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (load_res) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx <= n_widx;
        r_scr  <= n_scr;
        r_cell <= n_cell;
        r_fill <= n_fill;
        if (load_res) begin
            r_out_col  <= tcw_pkg::COL_IN_W'(n_col);
            r_out_row  <= tcw_pkg::ROW_IN_W'(n_row);
            r_out_lin  <= tcw_pkg::LIN_W'(32'(n_row) * SCREEN_COLS + 32'(n_col));
            r_out_scr  <= n_scr;
            r_out_cell <= n_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.col_now    = r_out_col;
    assign o_res.row_now    = r_out_row;
    assign o_res.linear_pos = r_out_lin;
    assign o_res.scrolled   = r_out_scr;
    assign o_res.cell_value = r_out_cell;

endmodule

>>> rtl/core/text_console_writer_core.sv
// Channel   Dir  Handshake          Payload
// i_cmd     in   valid/ready        mode, char_code, cursor_col, cursor_row, fill_entry
// o_res     out  valid/ready        col_now, row_now, linear_pos, scrolled, cell_value
// i_cfg     in   write enable only  text_attr in i_cfg_wdata
//
// An item passes the input register and a two-entry queue, then the sequencer.
// Put character, newline and set cursor finish in idle; read cell goes via read and done.
// A scroll walks the store once on one memory port pair.
// Clear screen fills the store with single writes of fill_entry.
// After reset a clearing pass over the store runs with i_cmd.ready low.
// A stalled result holds in the output register while the queue keeps taking items until full.
module text_console_writer_core #(
    parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tcw_cmd_if.sink                    i_cmd,
    tcw_res_if.source                  o_res,
    input  logic                       i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_wdata
);

    tcw_pkg::t_back_stat stat;
    tcw_pkg::t_cmd       q_in;
    tcw_pkg::t_cmd       q_head;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;

    tcw_front #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .i_q_full(q_full),
        .o_q_push(q_push),
        .o_q_data(q_in)
    );

    tcw_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_head (q_head)
    );

    tcw_back #(
        .SCREEN_COLS(SCREEN_COLS),
        .SCREEN_ROWS(SCREEN_ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_q_empty  (q_empty),
        .i_q_head   (q_head),
        .o_q_pop    (q_pop),
        .o_stat     (stat),
        .o_res      (o_res)
    );

endmodule

>>> rtl/core/tcw_checker.sv
module tcw_checker #(
    parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic [tcw_pkg::COL_IN_W-1:0] i_col_now,
    input logic [tcw_pkg::ROW_IN_W-1:0] i_row_now,
    input logic [tcw_pkg::LIN_W-1:0]    i_linear_pos,
    input logic                         i_scrolled,
    input logic [tcw_pkg::CELL_W-1:0]   i_cell_value
);

    // A stalled result keeps its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_col_now) &&
        $stable(i_row_now) && $stable(i_linear_pos) && $stable(i_scrolled) &&
        $stable(i_cell_value))
        else $error("stalled result changed");

    // The cursor never leaves the screen.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> int'(i_col_now) < SCREEN_COLS && int'(i_row_now) < SCREEN_ROWS)
        else $error("cursor off screen");

    // Where the screen fits the input widths, the linear position agrees with the row and column.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> SCREEN_COLS > 128 || SCREEN_ROWS > 32 ||
        i_linear_pos == tcw_pkg::LIN_W'(32'(i_row_now) * SCREEN_COLS + 32'(i_col_now)))
        else $error("linear position mismatch");

    // A scroll always leaves the cursor at the start of the last row, with no cell read.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_scrolled |-> i_col_now == '0 && i_cell_value == '0 &&
        i_row_now == tcw_pkg::ROW_IN_W'(SCREEN_ROWS - 1))
        else $error("scroll left cursor in wrong place");

endmodule

bind text_console_writer_core tcw_checker #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
) u_tcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_col_now   (o_res.col_now),
    .i_row_now   (o_res.row_now),
    .i_linear_pos(o_res.linear_pos),
    .i_scrolled  (o_res.scrolled),
    .i_cell_value(o_res.cell_value)
);

>>> dv/tb_text_console_writer_core.sv
module tb_text_console_writer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = tcw_pkg::DEF_SCREEN_COLS;
    localparam int ROWS  = tcw_pkg::DEF_SCREEN_ROWS;
    localparam int CELLS = COLS * ROWS;
    // A scroll or a clear walks the whole store; this covers either with margin.
    localparam int SETTLE_CYCLES = CELLS + 100;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        tcw_pkg::t_mode               mode;
        logic [tcw_pkg::CHAR_W-1:0]   ch;
        logic [tcw_pkg::COL_IN_W-1:0] col;
        logic [tcw_pkg::ROW_IN_W-1:0] row;
        logic [tcw_pkg::CELL_W-1:0]   fill;
    } t_console_cmd;

    typedef struct packed {
        logic [tcw_pkg::COL_IN_W-1:0] col;
        logic [tcw_pkg::ROW_IN_W-1:0] row;
        logic [tcw_pkg::LIN_W-1:0]    pos;
        logic                         scrolled;
        logic [tcw_pkg::CELL_W-1:0]   cell_val;
    } t_console_res;

    typedef struct packed {
        t_console_cmd cmd;
        logic         typed;
        t_console_res res;
    } t_dir_row;

    localparam int DIR_N = 24;
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        '{'{tcw_pkg::MODE_READ,   8'h00, 7'd0,   5'd0,  16'h0000}, 1'b1,
          '{0,  0,  0,    0, 16'h0F20}},
        '{'{tcw_pkg::MODE_READ,   8'hFF, 7'd127, 5'd31, 16'hFFFF}, 1'b1,
          '{0,  0,  0,    0, 16'h0F20}},
        '{'{tcw_pkg::MODE_PUTC,   8'h41, 7'd127, 5'd31, 16'hFFFF}, 1'b1,
          '{1,  0,  1,    0, 16'h0000}},
        '{'{tcw_pkg::MODE_READ,   8'h00, 7'd0,   5'd0,  16'h0000}, 1'b1,
          '{1,  0,  1,    0, 16'h0F41}},
        '{'{tcw_pkg::MODE_PUTC,   8'h00, 7'd0,   5'd0,  16'h0000}, 1'b0, '0},
        '{'{tcw_pkg::MODE_PUTC,   8'hFF, 7'd0,   5'd0,  16'h0000}, 1'b0, '0},
        '{'{tcw_pkg::MODE_READ,   8'h00, 7'd2,   5'd0,  16'h0000}, 1'b0, '0},
        '{'{tcw_pkg::MODE_PUTC,   8'h0A, 7'd5,   5'd5,  16'h1234}, 1'b1,
          '{0,  1,  80,   0, 16'h0000}},
        '{'{tcw_pkg::MODE_SETCUR, 8'h00, 7'd79,  5'd24, 16'h0000}, 1'b1,
          '{79, 24, 1999, 0, 16'h0000}},
        '{'{tcw_pkg::MODE_PUTC,   8'h5A, 7'd0,   5'd0,  16'h0000}, 1'b1,
          '{0,  24, 1920, 1, 16'h0000}},
        '{'{tcw_pkg::MODE_READ,   8'h00, 7'd79,  5'd23, 16'h0000}, 1'b0, '0},
        '{'{tcw_pkg::MODE_READ,   8'h00, 7'd0,   5'd0,  16'h0000}, 1'b0, '0},
        '{'{tcw_pkg::MODE_SETCUR, 8'h00, 7'd127, 5'd31, 16'h0000}, 1'b1,
          '{79, 24, 1999, 0, 16'h0000}},
        '{'{tcw_pkg::MODE_PUTC,   8'h0A, 7'd0,   5'd0,  16'h0000}, 1'b1,
          '{0,  24, 1920, 1, 16'h0000}},
        '{'{tcw_pkg::MODE_READ,   8'h00, 7'd79,  5'd22, 16'h0000}, 1'b0, '0},
        '{'{tcw_pkg::MODE_SETCUR, 8'h00, 7'd5,   5'd31, 16'h0000}, 1'b1,
          '{5,  24, 1925, 0, 16'h0000}},
        '{'{tcw_pkg::MODE_SETCUR, 8'hFF, 7'd127, 5'd3,  16'hFFFF}, 1'b1,
          '{79, 3,  319,  0, 16'h0000}},
        '{'{tcw_pkg::MODE_PUTC,   8'h7E, 7'd0,   5'd0,  16'h0000}, 1'b1,
          '{0,  4,  320,  0, 16'h0000}},
        '{'{tcw_pkg::MODE_CLEAR,  8'h0A, 7'd0,   5'd0,  16'hFFFF}, 1'b1,
          '{0,  0,  0,    0, 16'h0000}},
        '{'{tcw_pkg::MODE_READ,   8'h00, 7'd127, 5'd31, 16'h0000}, 1'b1,
          '{0,  0,  0,    0, 16'hFFFF}},
        '{'{tcw_pkg::MODE_READ,   8'h00, 7'd0,   5'd0,  16'h0000}, 1'b1,
          '{0,  0,  0,    0, 16'hFFFF}},
        '{'{tcw_pkg::MODE_CLEAR,  8'h00, 7'd127, 5'd0,  16'h0000}, 1'b1,
          '{0,  0,  0,    0, 16'h0000}},
        '{'{tcw_pkg::MODE_READ,   8'h00, 7'd40,  5'd12, 16'h0000}, 1'b1,
          '{0,  0,  0,    0, 16'h0000}},
        '{'{tcw_pkg::MODE_PUTC,   8'h0A, 7'd0,   5'd0,  16'h0000}, 1'b1,
          '{0,  1,  80,   0, 16'h0000}}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [tcw_pkg::ATTR_W-1:0] i_cfg_wdata;

    tcw_cmd_if cmd_if();
    tcw_res_if res_if();

    text_console_writer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Shadow copy of the console.
    logic [tcw_pkg::CELL_W-1:0] shadow_screen [CELLS];
    int                         shadow_col;
    int                         shadow_row;
    logic [tcw_pkg::ATTR_W-1:0] shadow_attr;

    t_console_res cursor_q [$];
    int           error_count;
    int           idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic scroll_if_past_end();
        int i;
        shadow_row++;
        if (shadow_row < ROWS) begin
            return 1'b0;
        end
        for (i = 0; i < COLS * (ROWS - 1); i++) begin
            shadow_screen[i] = shadow_screen[i + COLS];
        end
        for (i = COLS * (ROWS - 1); i < CELLS; i++) begin
            shadow_screen[i] = {shadow_attr, tcw_pkg::SPACE_CODE};
        end
        shadow_row = ROWS - 1;
        return 1'b1;
    endfunction

    function automatic t_console_res step_console(t_console_cmd c);
        t_console_res r;
        int           c_col;
        int           c_row;
        int           i;
        r     = '0;
        c_col = (int'(c.col) > COLS - 1) ? COLS - 1 : int'(c.col);
        c_row = (int'(c.row) > ROWS - 1) ? ROWS - 1 : int'(c.row);
        case (c.mode)
            tcw_pkg::MODE_PUTC: begin
                if (c.ch == tcw_pkg::NEWLINE_CODE) begin
                    shadow_col = 0;
                    r.scrolled = scroll_if_past_end();
                end else begin
                    shadow_screen[shadow_row * COLS + shadow_col] = {shadow_attr, c.ch};
                    shadow_col++;
                    if (shadow_col >= COLS) begin
                        shadow_col = 0;
                        r.scrolled = scroll_if_past_end();
                    end
                end
            end
            tcw_pkg::MODE_CLEAR: begin
                for (i = 0; i < CELLS; i++) begin
                    shadow_screen[i] = c.fill;
                end
                shadow_col = 0;
                shadow_row = 0;
            end
            tcw_pkg::MODE_SETCUR: begin
                shadow_col = c_col;
                shadow_row = c_row;
            end
            default: begin
                r.cell_val = shadow_screen[c_row * COLS + c_col];
            end
        endcase
        r.col = tcw_pkg::COL_IN_W'(shadow_col);
        r.row = tcw_pkg::ROW_IN_W'(shadow_row);
        r.pos = tcw_pkg::LIN_W'(shadow_row * COLS + shadow_col);
        return r;
    endfunction

    function automatic t_console_cmd random_console_cmd();
        t_console_cmd c;
        int           pick;
        c.ch   = tcw_pkg::CHAR_W'($urandom);
        c.col  = tcw_pkg::COL_IN_W'($urandom);
        c.row  = tcw_pkg::ROW_IN_W'($urandom);
        c.fill = tcw_pkg::CELL_W'($urandom);
        pick   = $urandom_range(99);
        if (pick < 3) begin
            c.mode = tcw_pkg::MODE_CLEAR;
            if ($urandom_range(1) == 0) begin
                c.fill = {tcw_pkg::CHAR_W'($urandom), tcw_pkg::SPACE_CODE};
            end
        end else if (pick < 15) begin
            c.mode = tcw_pkg::MODE_SETCUR;
            if ($urandom_range(4) != 0) begin
                c.col = tcw_pkg::COL_IN_W'($urandom_range(COLS - 1));
                // Parking on the last row makes scrolls frequent.
                c.row = ($urandom_range(2) == 0) ? tcw_pkg::ROW_IN_W'(ROWS - 1)
                                                 : tcw_pkg::ROW_IN_W'($urandom_range(ROWS - 1));
            end
        end else if (pick < 32) begin
            c.mode = tcw_pkg::MODE_READ;
            if ($urandom_range(1) == 0) begin
                // Read back what was most likely just written.
                c.row = tcw_pkg::ROW_IN_W'(shadow_row);
                c.col = tcw_pkg::COL_IN_W'((shadow_col > 0) ? shadow_col - 1 : 0);
            end
        end else begin
            c.mode = tcw_pkg::MODE_PUTC;
            if ($urandom_range(11) == 0) begin
                c.ch = tcw_pkg::NEWLINE_CODE;
            end
        end
        return c;
    endfunction

    task automatic send_console_cmd(t_console_cmd c, logic typed, t_console_res typed_res);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) begin
            gap++;
        end
        if (idle_pct > 0 && $urandom_range(199) == 0) begin
            cmd_if.valid <= 1'b0;
            wait (cursor_q.size() == 0);
            @(posedge i_clk);
        end else if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.mode       <= c.mode;
        cmd_if.char_code  <= c.ch;
        cmd_if.cursor_col <= c.col;
        cmd_if.cursor_row <= c.row;
        cmd_if.fill_entry <= c.fill;
        do @(posedge i_clk); while (!cmd_if.ready);
        if (typed) begin
            void'(step_console(c));
            cursor_q.push_back(typed_res);
        end else begin
            cursor_q.push_back(step_console(c));
        end
    endtask

    task automatic settle_console();
        cmd_if.valid <= 1'b0;
        wait (cursor_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_text_attr(logic [tcw_pkg::ATTR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_attr = value;
    endtask

    task automatic run_random_chars(int count, int pct);
        idle_pct = pct;
        repeat (count) send_console_cmd(random_console_cmd(), 1'b0, '0);
    endtask

    task automatic check_cursor_result();
        t_console_res got;
        t_console_res want;
        got = '{res_if.col_now, res_if.row_now, res_if.linear_pos, res_if.scrolled,
                res_if.cell_value};
        if (cursor_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: unexpected result col=%0d row=%0d pos=%0d scr=%0b cell=%h",
                         $realtime, got.col, got.row, got.pos, got.scrolled, got.cell_val);
            end
        end else begin
            want = cursor_q.pop_front();
            if (got.col !== want.col || got.row !== want.row || got.pos !== want.pos
                || got.scrolled !== want.scrolled || got.cell_val !== want.cell_val) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("%0t: mismatch exp col=%0d row=%0d pos=%0d scr=%0b cell=%h",
                             $realtime, want.col, want.row, want.pos, want.scrolled,
                             want.cell_val);
                    $display("%0t:          got col=%0d row=%0d pos=%0d scr=%0b cell=%h",
                             $realtime, got.col, got.row, got.pos, got.scrolled,
                             got.cell_val);
                end
            end
        end
    endtask

    // Result side: the ready seen here is the one the block sampled at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            check_cursor_result();
        end
        res_if.ready <= ($urandom_range(99) >= idle_pct);
    end

    initial begin
        int i;
        error_count = 0;
        idle_pct    = 17;
        shadow_col  = 0;
        shadow_row  = 0;
        shadow_attr = tcw_pkg::RESET_ATTR;
        for (i = 0; i < CELLS; i++) begin
            shadow_screen[i] = tcw_pkg::RESET_CELL;
        end
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        cmd_if.valid      <= 1'b0;
        cmd_if.mode       <= tcw_pkg::MODE_PUTC;
        cmd_if.char_code  <= '0;
        cmd_if.cursor_col <= '0;
        cmd_if.cursor_row <= '0;
        cmd_if.fill_entry <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < DIR_N; i++) begin
            send_console_cmd(DIR_TAB[i].cmd, DIR_TAB[i].typed, DIR_TAB[i].res);
        end

        settle_console();
        write_text_attr(8'h00);
        run_random_chars(250, 17);

        // Long stretch with both sides always willing.
        settle_console();
        write_text_attr(8'hFF);
        run_random_chars(250, 0);

        settle_console();
        write_text_attr(tcw_pkg::ATTR_W'($urandom));
        run_random_chars(300, 17);

        settle_console();
        write_text_attr(tcw_pkg::RESET_ATTR);
        run_random_chars(250, 17);

        settle_console();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
